// ===== rtl/core/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and constants of the matrix multiply engine core.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

  localparam int MAX_DIM    = 16;
  localparam int DIM_W      = 4;
  localparam int SIZE_W     = 5;
  localparam int ADDR_W     = 8;
  localparam int MEM_DEPTH  = 256;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET  = 5'd16;
  localparam logic [SIZE_W-1:0] SIZE_MAX    = 5'd16;
  localparam logic [31:0]       FP_DEF_NAN  = 32'hFFC0_0000;
  localparam logic [31:0]       FP_QUIET    = 32'h0040_0000;

  typedef enum logic [1:0] {
    OP_WR_A    = 2'd0,
    OP_WR_B    = 2'd1,
    OP_COMPUTE = 2'd2
  } op_e;

  typedef struct packed {
    op_e              kind;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic [31:0]      value;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_MUL1,
    B_MUL2,
    B_MUL3,
    B_ADD1,
    B_ADD2,
    B_DONE
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/mme_ram.sv =====
// ----------------------------------------------------------------------------
// mme_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mme_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// mme_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire mme_pkg::cmd_t wdata_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output mme_pkg::cmd_t      rdata_o,
  output logic               empty_o
);
  import mme_pkg::*;

  cmd_t                  mem_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_PTR_W:0]   count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mme_front.sv =====
// ----------------------------------------------------------------------------
// mme_front
// Front end: size register, input handshake and item classification.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [mme_pkg::SIZE_W-1:0] cfg_data_i,
  input  wire logic                       push_i,
  output logic                            full_o,
  input  wire logic [1:0]                 op_i,
  input  wire logic [mme_pkg::DIM_W-1:0]  row_index_i,
  input  wire logic [mme_pkg::DIM_W-1:0]  col_index_i,
  input  wire logic [31:0]                element_value_i,
  output logic                            q_push_o,
  output mme_pkg::cmd_t                   q_cmd_o,
  input  wire logic                       q_full_i,
  output logic [mme_pkg::SIZE_W-1:0]      eff_size_o
);
  import mme_pkg::*;

  logic [SIZE_W-1:0] size_q;
  logic              in_range, op_ok;

  assign cfg_ready_o = 1'b1;
  assign full_o      = q_full_i;
  assign eff_size_o  = (size_q > SIZE_MAX) ? SIZE_MAX : size_q;

  // size zero leaves nothing in range
  assign in_range = ({1'b0, row_index_i} < eff_size_o) && ({1'b0, col_index_i} < eff_size_o);

  always_comb begin
    op_ok = 1'b0;
    unique case (op_i)
      OP_WR_A, OP_WR_B, OP_COMPUTE: op_ok = 1'b1;
      default: op_ok = 1'b0;
    endcase
  end

  assign q_push_o      = push_i && !q_full_i && in_range && op_ok;
  assign q_cmd_o.kind  = op_e'(op_i);
  assign q_cmd_o.row   = row_index_i;
  assign q_cmd_o.col   = col_index_i;
  assign q_cmd_o.value = element_value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= cfg_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mme_fmul.sv =====
// ----------------------------------------------------------------------------
// mme_fmul
// Binary32 multiplier, round to nearest even, three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_fmul (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] p_o
);
  import mme_pkg::*;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] cnt;
    logic       found;
    cnt   = '0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else      cnt   = cnt + 1'b1;
      end
    end
    return cnt;
  endfunction

  // stage 1: classify, pre-normalise subnormal significands
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  logic        spec;
  logic [31:0] spec_val;
  logic [23:0] sig_a, sig_b;
  logic [4:0]  lz_a, lz_b;
  logic signed [9:0] exp_a, exp_b;

  always_comb begin
    a_nan  = (a_i[30:23] == 8'hFF) && (a_i[22:0] != '0);
    b_nan  = (b_i[30:23] == 8'hFF) && (b_i[22:0] != '0);
    a_inf  = (a_i[30:23] == 8'hFF) && (a_i[22:0] == '0);
    b_inf  = (b_i[30:23] == 8'hFF) && (b_i[22:0] == '0);
    a_zero = (a_i[30:0] == '0);
    b_zero = (b_i[30:0] == '0);
    sgn    = a_i[31] ^ b_i[31];
    spec     = 1'b1;
    spec_val = {sgn, 31'd0};
    if (a_nan) begin
      spec_val = a_i | FP_QUIET;
    end else if (b_nan) begin
      spec_val = b_i | FP_QUIET;
    end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
      spec_val = FP_DEF_NAN;
    end else if (a_inf || b_inf) begin
      spec_val = {sgn, 8'hFF, 23'd0};
    end else if (a_zero || b_zero) begin
      spec_val = {sgn, 31'd0};
    end else begin
      spec = 1'b0;
    end
    sig_a = {a_i[30:23] != '0, a_i[22:0]};
    sig_b = {b_i[30:23] != '0, b_i[22:0]};
    lz_a  = lzc24(sig_a);
    lz_b  = lzc24(sig_b);
    exp_a = ((a_i[30:23] == '0) ? 10'sd1 : $signed({2'b00, a_i[30:23]}))
            - $signed({5'd0, lz_a});
    exp_b = ((b_i[30:23] == '0) ? 10'sd1 : $signed({2'b00, b_i[30:23]}))
            - $signed({5'd0, lz_b});
  end

  logic              s1_spec_q, s1_sign_q;
  logic [31:0]       s1_spec_val_q;
  logic [23:0]       s1_ma_q, s1_mb_q;
  logic signed [9:0] s1_exp_q;

  always_ff @(posedge clk_i) begin
    s1_spec_q     <= spec;
    s1_spec_val_q <= spec_val;
    s1_sign_q     <= sgn;
    s1_ma_q       <= sig_a << lz_a;
    s1_mb_q       <= sig_b << lz_b;
    s1_exp_q      <= exp_a + exp_b - 10'sd127;
  end

  // stage 2: significand product
  logic              s2_spec_q, s2_sign_q;
  logic [31:0]       s2_spec_val_q;
  logic [47:0]       s2_prod_q;
  logic signed [9:0] s2_exp_q;

  always_ff @(posedge clk_i) begin
    s2_spec_q     <= s1_spec_q;
    s2_spec_val_q <= s1_spec_val_q;
    s2_sign_q     <= s1_sign_q;
    s2_prod_q     <= s1_ma_q * s1_mb_q;
    s2_exp_q      <= s1_exp_q;
  end

  // stage 3: normalise, denormalise on underflow, round
  logic [47:0]       norm, den;
  logic signed [9:0] e_res, t_sh;
  logic [5:0]        sh;
  logic              lost, g, st, rnd;
  logic [23:0]       mant;
  logic [7:0]        base;
  logic [31:0]       res;

  always_comb begin
    norm  = s2_prod_q[47] ? s2_prod_q : (s2_prod_q << 1);
    e_res = s2_exp_q + $signed({9'd0, s2_prod_q[47]});
    t_sh  = 10'sd1 - e_res;
    if (e_res < 10'sd1) begin
      sh   = (t_sh > 10'sd49) ? 6'd49 : 6'(t_sh);
      base = 8'd0;
    end else begin
      sh   = 6'd0;
      base = 8'(e_res - 10'sd1);
    end
    den  = norm >> sh;
    lost = |(norm & ~({48{1'b1}} << sh));
    mant = den[47:24];
    g    = den[23];
    st   = (|den[22:0]) | lost;
    rnd  = g & (st | mant[0]);
    if (s2_spec_q) begin
      res = s2_spec_val_q;
    end else if (e_res >= 10'sd255) begin
      res = {s2_sign_q, 8'hFF, 23'd0};
    end else begin
      res = {s2_sign_q, {base, 23'd0} + {7'd0, mant} + {30'd0, rnd}};
    end
  end

  always_ff @(posedge clk_i) begin
    p_o <= res;
  end

endmodule

`default_nettype wire

// ===== rtl/core/mme_fadd.sv =====
// ----------------------------------------------------------------------------
// mme_fadd
// Binary32 adder, round to nearest even; align/add stage, then normalise.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_fadd (
  input  wire logic        clk_i,
  input  wire logic [31:0] x_i,
  input  wire logic [31:0] y_i,
  output logic      [31:0] sum_o
);
  import mme_pkg::*;

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] cnt;
    logic       found;
    cnt   = '0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else      cnt   = cnt + 1'b1;
      end
    end
    return cnt;
  endfunction

  logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
  logic        spec, swap;
  logic [31:0] spec_val, big, sml;
  logic [23:0] big_sig, sml_sig;
  logic [7:0]  big_exp, sml_exp, diff;
  logic [26:0] big_w, sml_w0, sml_sh;
  logic        sml_lost;
  logic [27:0] sum_w;

  always_comb begin
    x_nan  = (x_i[30:23] == 8'hFF) && (x_i[22:0] != '0);
    y_nan  = (y_i[30:23] == 8'hFF) && (y_i[22:0] != '0);
    x_inf  = (x_i[30:23] == 8'hFF) && (x_i[22:0] == '0);
    y_inf  = (y_i[30:23] == 8'hFF) && (y_i[22:0] == '0);
    x_zero = (x_i[30:0] == '0);
    y_zero = (y_i[30:0] == '0);
    spec     = 1'b1;
    spec_val = x_i;
    if (x_nan) begin
      spec_val = x_i | FP_QUIET;
    end else if (y_nan) begin
      spec_val = y_i | FP_QUIET;
    end else if (x_inf && y_inf && (x_i[31] != y_i[31])) begin
      spec_val = FP_DEF_NAN;
    end else if (x_inf) begin
      spec_val = x_i;
    end else if (y_inf) begin
      spec_val = y_i;
    end else if (x_zero && y_zero) begin
      spec_val = {x_i[31] & y_i[31], 31'd0};
    end else if (x_zero) begin
      spec_val = y_i;
    end else if (y_zero) begin
      spec_val = x_i;
    end else begin
      spec = 1'b0;
    end
    swap     = (y_i[30:0] > x_i[30:0]);
    big      = swap ? y_i : x_i;
    sml      = swap ? x_i : y_i;
    big_sig  = {big[30:23] != '0, big[22:0]};
    sml_sig  = {sml[30:23] != '0, sml[22:0]};
    big_exp  = (big[30:23] == '0) ? 8'd1 : big[30:23];
    sml_exp  = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
    diff     = big_exp - sml_exp;
    big_w    = {big_sig, 3'd0};
    sml_w0   = {sml_sig, 3'd0};
    sml_sh   = sml_w0 >> diff;
    sml_lost = |(sml_w0 & ~({27{1'b1}} << diff));
    sml_sh   = {sml_sh[26:1], sml_sh[0] | sml_lost};
    if (big[31] ^ sml[31]) begin
      sum_w = {1'b0, big_w} - {1'b0, sml_sh};
    end else begin
      sum_w = {1'b0, big_w} + {1'b0, sml_sh};
    end
  end

  logic        s1_spec_q, s1_sign_q;
  logic [31:0] s1_spec_val_q;
  logic [7:0]  s1_exp_q;
  logic [27:0] s1_sum_q;

  always_ff @(posedge clk_i) begin
    s1_spec_q     <= spec;
    s1_spec_val_q <= spec_val;
    s1_sign_q     <= big[31];
    s1_exp_q      <= big_exp;
    s1_sum_q      <= sum_w;
  end

  logic [26:0] nrm;
  logic [8:0]  e_res, lim;
  logic [4:0]  lz;
  logic [8:0]  shl;
  logic [23:0] mant;
  logic        rnd;
  logic [7:0]  base;

  always_comb begin
    lz  = lzc27(s1_sum_q[26:0]);
    lim = {1'b0, s1_exp_q} - 9'd1;
    shl = ({4'd0, lz} < lim) ? {4'd0, lz} : lim;
    if (s1_sum_q[27]) begin
      nrm   = {s1_sum_q[27:2], s1_sum_q[1] | s1_sum_q[0]};
      e_res = {1'b0, s1_exp_q} + 9'd1;
    end else begin
      nrm   = s1_sum_q[26:0] << shl;
      e_res = {1'b0, s1_exp_q} - shl;
    end
    mant = nrm[26:3];
    rnd  = nrm[2] & ((|nrm[1:0]) | mant[0]);
    base = 8'(e_res - 9'd1);
    if (s1_spec_q) begin
      sum_o = s1_spec_val_q;
    end else if (s1_sum_q == '0) begin
      sum_o = 32'd0;
    end else if (e_res >= 9'd255) begin
      sum_o = {s1_sign_q, 8'hFF, 23'd0};
    end else begin
      sum_o = {s1_sign_q, {base, 23'd0} + {7'd0, mant} + {30'd0, rnd}};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mme_back.sv =====
// ----------------------------------------------------------------------------
// mme_back
// Back end: element stores, dot-product sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_empty_i,
  input  wire mme_pkg::cmd_t              q_cmd_i,
  output logic                            q_pop_o,
  input  wire logic [mme_pkg::SIZE_W-1:0] eff_size_i,
  output logic                            res_empty_o,
  input  wire logic                       res_pop_i,
  output logic [mme_pkg::DIM_W-1:0]       result_row_o,
  output logic [mme_pkg::DIM_W-1:0]       result_col_o,
  output logic [31:0]                     product_value_o
);
  import mme_pkg::*;

  back_state_e       state_q, state_d;
  logic [SIZE_W-1:0] k_q, k_d, k_next;
  logic [DIM_W-1:0]  row_q, row_d, col_q, col_d;
  logic [31:0]       acc_q, acc_d;
  logic              res_valid_q, res_load;
  logic [DIM_W-1:0]  res_row_q, res_col_q;
  logic [31:0]       res_val_q;
  logic              a_we, b_we;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [31:0]       a_rdata, b_rdata, prod, sum;

  assign waddr   = {q_cmd_i.row, q_cmd_i.col};
  assign raddr_a = {row_q, k_q[DIM_W-1:0]};
  assign raddr_b = {k_q[DIM_W-1:0], col_q};
  assign k_next  = k_q + 1'b1;

  mme_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (waddr),
    .wdata_i (q_cmd_i.value),
    .raddr_i (raddr_a),
    .rdata_o (a_rdata)
  );

  mme_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (waddr),
    .wdata_i (q_cmd_i.value),
    .raddr_i (raddr_b),
    .rdata_o (b_rdata)
  );

  mme_fmul u_fmul (
    .clk_i (clk_i),
    .a_i   (a_rdata),
    .b_i   (b_rdata),
    .p_o   (prod)
  );

  mme_fadd u_fadd (
    .clk_i (clk_i),
    .x_i   (acc_q),
    .y_i   (prod),
    .sum_o (sum)
  );

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    row_d    = row_q;
    col_d    = col_q;
    acc_d    = acc_q;
    q_pop_o  = 1'b0;
    a_we     = 1'b0;
    b_we     = 1'b0;
    res_load = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          unique case (q_cmd_i.kind)
            OP_WR_A: a_we = 1'b1;
            OP_WR_B: b_we = 1'b1;
            OP_COMPUTE: begin
              row_d   = q_cmd_i.row;
              col_d   = q_cmd_i.col;
              k_d     = '0;
              acc_d   = 32'd0;
              state_d = B_READ;
            end
            default: ;
          endcase
        end
      end
      B_READ: state_d = B_MUL1;
      B_MUL1: state_d = B_MUL2;
      B_MUL2: state_d = B_MUL3;
      B_MUL3: state_d = B_ADD1;
      B_ADD1: state_d = B_ADD2;
      B_ADD2: begin
        acc_d = sum;
        if (k_next == eff_size_i) begin
          state_d = B_DONE;
        end else begin
          k_d     = k_next;
          state_d = B_READ;
        end
      end
      B_DONE: begin
        if (!res_valid_q || res_pop_i) begin
          res_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_load | (res_valid_q & ~res_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    row_q <= row_d;
    col_q <= col_d;
    acc_q <= acc_d;
    if (res_load) begin
      res_row_q <= row_q;
      res_col_q <= col_q;
      res_val_q <= acc_q;
    end
  end

  assign res_empty_o     = !res_valid_q;
  assign result_row_o    = res_row_q;
  assign result_col_o    = res_col_q;
  assign product_value_o = res_val_q;

endmodule

`default_nettype wire

// ===== rtl/core/matrix_multiply_engine_core.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_engine_core
// Square binary32 matrix multiply engine with queue-style ports.
// ----------------------------------------------------------------------------
// Write transactions load one A or B element into its store when popped;
// a compute transaction for C[row][col] occupies the back end while each
// of the size terms is read from the element stores, taken through the
// three-stage multiplier and then through the adder into the running sum
// before the next term starts. A four-entry command queue sits in front of
// the back end and a result register behind it, so items keep being taken
// while a result waits. Out-of-range indices and the unused op code are
// dropped on entry.
`default_nettype none

module matrix_multiply_engine_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [mme_pkg::SIZE_W-1:0] cfg_data_i,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [1:0]                 op_i,
  input  wire logic [mme_pkg::DIM_W-1:0]  row_index_i,
  input  wire logic [mme_pkg::DIM_W-1:0]  col_index_i,
  input  wire logic [31:0]                element_value_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [mme_pkg::DIM_W-1:0]       result_row_o,
  output logic [mme_pkg::DIM_W-1:0]       result_col_o,
  output logic [31:0]                     product_value_o
);
  import mme_pkg::*;

  logic              q_push, q_full, q_pop, q_empty;
  cmd_t              q_wcmd, q_rcmd;
  logic [SIZE_W-1:0] eff_size;

  mme_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .push_i          (push),
    .full_o          (full),
    .op_i            (op_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .q_push_o        (q_push),
    .q_cmd_o         (q_wcmd),
    .q_full_i        (q_full),
    .eff_size_o      (eff_size)
  );

  mme_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wcmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rcmd),
    .empty_o (q_empty)
  );

  mme_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_cmd_i         (q_rcmd),
    .q_pop_o         (q_pop),
    .eff_size_i      (eff_size),
    .res_empty_o     (empty),
    .res_pop_i       (pop),
    .result_row_o    (result_row_o),
    .result_col_o    (result_col_o),
    .product_value_o (product_value_o)
  );

endmodule

`default_nettype wire
